// File: hw/rtl/pet_pkg.sv
// pet_pkg: shared types and constants for the particle emitter tick core
// no dependencies
package pet_pkg;
	localparam int unsigned VEL_W = 40;
	localparam int unsigned POS_W = 48;
	localparam int unsigned LIFE_W = 25;
	localparam int unsigned ACC_W = 16;
	localparam int unsigned DT_W = 10;
	localparam int unsigned RATE_W = 33;
	localparam int unsigned DROP_W = 16;
	localparam int unsigned CFG_W = 48;
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [LIFE_W-1:0] LIFE_ONE = 25'h100_0000;

	localparam logic [CFG_IDX_W-1:0] REG_VEL_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_RATE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_DECAY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIFE_DECAY = 3'd6;

	// one particle's per-axis state for the axis unit
	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic signed [VEL_W-1:0] vel;
	} axis_t;
endpackage

// File: hw/rtl/pet_axis.sv
// pet_axis: euler update of one axis, velocity then position, both saturated
// depends on pet_pkg; two registered stages
module pet_axis (
	input  logic                            clk,
	input  logic                            en,
	input  logic [pet_pkg::DT_W-1:0]        dt,
	input  logic signed [pet_pkg::ACC_W-1:0] acc,
	input  pet_pkg::axis_t                  din,
	output pet_pkg::axis_t                  dout
);
	localparam int unsigned SV_W = pet_pkg::VEL_W + 2;
	localparam int unsigned SP_W = pet_pkg::POS_W + 4;
	localparam logic signed [SV_W-1:0] VMAX = SV_W'({1'b0, {(pet_pkg::VEL_W-1){1'b1}}});
	localparam logic signed [SV_W-1:0] VMIN = -VMAX - SV_W'(1);
	localparam logic signed [SP_W-1:0] PMAX = SP_W'({1'b0, {(pet_pkg::POS_W-1){1'b1}}});
	localparam logic signed [SP_W-1:0] PMIN = -PMAX - SP_W'(1);

	logic signed [pet_pkg::ACC_W+pet_pkg::DT_W:0] adt;
	logic signed [SV_W-1:0] vsum;
	logic signed [pet_pkg::VEL_W-1:0] vsat;
	logic signed [pet_pkg::POS_W-1:0] pos_s1;
	logic signed [pet_pkg::VEL_W-1:0] vel_s1;
	logic signed [pet_pkg::VEL_W+pet_pkg::DT_W:0] vdt;
	logic signed [SP_W-1:0] psum;
	logic signed [pet_pkg::POS_W-1:0] psat;

	assign adt = acc * $signed({1'b0, dt});
	assign vsum = SV_W'(din.vel) + SV_W'(adt);
	always_comb begin
		if (vsum > VMAX) vsat = VMAX[pet_pkg::VEL_W-1:0];
		else if (vsum < VMIN) vsat = VMIN[pet_pkg::VEL_W-1:0];
		else vsat = vsum[pet_pkg::VEL_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= din.pos;
			vel_s1 <= vsat;
		end
	end

	assign vdt = vel_s1 * $signed({1'b0, dt});
	assign psum = SP_W'(pos_s1) + SP_W'(vdt);
	always_comb begin
		if (psum > PMAX) psat = PMAX[pet_pkg::POS_W-1:0];
		else if (psum < PMIN) psat = PMIN[pet_pkg::POS_W-1:0];
		else psat = psum[pet_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout.pos <= psat;
			dout.vel <= vel_s1;
		end
	end
endmodule

// File: hw/rtl/particle_emitter_tick_core.sv
// particle_emitter_tick_core: fixed-point particle emitter, one tick per transfer
// depends on pet_pkg and pet_axis
//
// Input channel (in_valid/in_ready): one tick with dt_ms, restart and the
// emitter origin. Output channel (out_valid/out_ready): one record per live
// particle in slot order, last set on the final one, or one record with
// valid_res low when no particle is live.
// Configuration: write cfg_we with cfg_index/cfg_data while idle.
// A tick runs a slot sweep: every slot is read from the state memories,
// emitted into if free and owed, integrated through a four-stage pipe and
// written back. The sweep issues one slot per cycle when the output is
// free, and output stalls lengthen a tick.
// A record leaves only when the one before it was taken; a stalled receiver
// holds the sweep. Emission bookkeeping runs in ST_EMIT before the sweep.
// Reset clears the live bits, the running rate, the carried fraction and the
// registers to their defaults; the position, velocity and life memories are
// left uninitialized and are only read for live slots.
module particle_emitter_tick_core #(
	parameter int unsigned MAX_PARTICLES = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [pet_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pet_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [pet_pkg::DT_W-1:0]          dt_ms,
	input  logic                              restart,
	input  logic signed [pet_pkg::POS_W-1:0]  origin_x,
	input  logic signed [pet_pkg::POS_W-1:0]  origin_y,
	input  logic signed [pet_pkg::POS_W-1:0]  origin_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              valid_res,
	output logic                              last,
	output logic signed [pet_pkg::POS_W-1:0]  pos_x,
	output logic signed [pet_pkg::POS_W-1:0]  pos_y,
	output logic signed [pet_pkg::POS_W-1:0]  pos_z,
	output logic [pet_pkg::LIFE_W-1:0]        life_left,
	output logic [pet_pkg::DROP_W-1:0]        dropped_count
);
	localparam int unsigned IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
	localparam logic [CW-1:0] LAST_SLOT = CW'(MAX_PARTICLES - 1);
	localparam int unsigned NW = 28; // count of new particles: 33+10-16+1

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EMIT  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMPTY = 5'b10000
	} state_t;

	// configuration
	logic signed [pet_pkg::VEL_W-1:0] vel0_q [3];
	logic [pet_pkg::CFG_W-1:0] accel_q;
	logic [31:0] emit_rate_q, rate_decay_q;
	logic [pet_pkg::LIFE_W-1:0] life_decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel0_q[0] <= '0;
			vel0_q[1] <= '0;
			vel0_q[2] <= '0;
			accel_q <= '0;
			emit_rate_q <= 32'd65536;
			rate_decay_q <= 32'd6554;
			life_decay_q <= 25'd16777;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pet_pkg::REG_VEL_X: vel0_q[0] <= cfg_data[pet_pkg::VEL_W-1:0];
				pet_pkg::REG_VEL_Y: vel0_q[1] <= cfg_data[pet_pkg::VEL_W-1:0];
				pet_pkg::REG_VEL_Z: vel0_q[2] <= cfg_data[pet_pkg::VEL_W-1:0];
				pet_pkg::REG_ACCEL: accel_q <= cfg_data;
				pet_pkg::REG_EMIT_RATE: emit_rate_q <= cfg_data[31:0];
				pet_pkg::REG_RATE_DECAY: rate_decay_q <= cfg_data[31:0];
				pet_pkg::REG_LIFE_DECAY: life_decay_q <= cfg_data[pet_pkg::LIFE_W-1:0];
				default: ;
			endcase
		end
	end

	state_t state_q;
	logic [pet_pkg::DT_W-1:0] dt_q;
	logic signed [pet_pkg::POS_W-1:0] org_q [3];
	logic [pet_pkg::RATE_W-1:0] rate_q;
	logic [15:0] frac_q;
	logic [NW-1:0] owed_q;
	logic [pet_pkg::DROP_W-1:0] drop_q;
	logic [pet_pkg::RATE_W+pet_pkg::DT_W-1:0] prod_q, dec_q;
	logic [MAX_PARTICLES-1:0] live_q;
	logic [CW-1:0] slot_q;
	logic any_q;

	// state memories, one entry per slot
	pet_pkg::axis_t mem_ax [3][MAX_PARTICLES];
	logic [pet_pkg::LIFE_W-1:0] mem_life [MAX_PARTICLES];

	// pipeline: s1 memory read, s2/s3 axis unit and life decay, s4 writeback
	logic v_s1, v_s2, v_s3, v_s4;
	logic new_s1;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3;
	pet_pkg::axis_t rd_s1 [3];
	logic [pet_pkg::LIFE_W-1:0] life_s1;
	pet_pkg::axis_t ain [3], aout [3];
	logic [pet_pkg::LIFE_W-1:0] life_s2, life_s3;
	logic [pet_pkg::LIFE_W+pet_pkg::DT_W-1:0] ldec_s2;
	logic alive_s3;
	logic [IW-1:0] idx_s4_q;
	logic alive_s4_q, adv_s4_q;

	// output record
	logic out_v_q;
	logic hold_v_q;
	logic [pet_pkg::LIFE_W-1:0] h_life_q;
	logic signed [pet_pkg::POS_W-1:0] h_pos_q [3];
	logic r_last_q, r_valid_q;
	logic signed [pet_pkg::POS_W-1:0] r_pos_q [3];
	logic [pet_pkg::LIFE_W-1:0] r_life_q;
	logic [pet_pkg::DROP_W-1:0] r_drop_q;

	logic pipe_busy, issue, adv, out_free;
	logic [pet_pkg::RATE_W-1:0] rate_eff;
	logic [16:0] fsum;
	logic [IW-1:0] slot_idx;
	logic owed_any;
	logic [NW-1:0] owed_new, owed_over;
	logic [CW-1:0] nfree;
	logic [pet_pkg::DROP_W-1:0] drop_new;

	assign slot_idx = slot_q[IW-1:0];
	assign owed_any = (owed_q != '0);
	assign out_free = !out_v_q || out_ready;
	// pipe advances when the holding slot can take what reaches s4
	assign adv = !(hold_v_q && !out_free && v_s3);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;
	assign issue = (state_q == ST_SWEEP) && adv && (slot_q <= LAST_SLOT);
	assign in_ready = (state_q == ST_IDLE);

	assign rate_eff = restart ? {1'b0, emit_rate_q} : rate_q;
	assign fsum = {1'b0, frac_q} + {1'b0, prod_q[15:0]};

	// new particles beyond the free slots are dropped
	always_comb begin
		nfree = '0;
		for (int i = 0; i < MAX_PARTICLES; i++) nfree = nfree + CW'(!live_q[i]);
	end
	assign owed_new = NW'(prod_q >> 16) + NW'(fsum[16]);
	assign owed_over = (owed_new > NW'(nfree)) ? owed_new - NW'(nfree) : '0;
	assign drop_new = (owed_over > NW'(16'hFFFF)) ? 16'hFFFF : owed_over[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rate_q <= '0;
			frac_q <= '0;
			owed_q <= '0;
			drop_q <= '0;
			live_q <= '0;
			slot_q <= '0;
			any_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						rate_q <= rate_eff;
						state_q <= ST_EMIT;
						slot_q <= '0;
						any_q <= 1'b0;
						owed_q <= '0;
						drop_q <= '0;
					end
				end
				ST_EMIT: begin
					if (rate_q != '0) begin
						owed_q <= owed_new;
						drop_q <= drop_new;
						frac_q <= fsum[15:0];
						rate_q <= (dec_q >= (pet_pkg::RATE_W+pet_pkg::DT_W)'(rate_q)) ? '0
							: rate_q - dec_q[pet_pkg::RATE_W-1:0];
					end
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (issue) begin
						slot_q <= slot_q + CW'(1);
						if (!live_q[slot_idx] && owed_any) begin
							live_q[slot_idx] <= 1'b1;
							owed_q <= owed_q - NW'(1);
						end
					end
					if (slot_q > LAST_SLOT) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy && !hold_v_q && out_free) begin
						state_q <= any_q ? ST_IDLE : ST_EMPTY;
					end
				end
				ST_EMPTY: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (v_s4 && adv_s4_q) begin
				if (!alive_s4_q) live_q[idx_s4_q] <= 1'b0;
				else any_q <= 1'b1;
			end
		end
	end

	// tick products
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			dt_q <= dt_ms;
			org_q[0] <= origin_x;
			org_q[1] <= origin_y;
			org_q[2] <= origin_z;
			prod_q <= rate_eff * dt_ms;
			dec_q <= {1'b0, rate_decay_q} * dt_ms;
		end
	end

	// s1: memory read, new particles replace the read data
	logic live_now, make_new;
	assign live_now = live_q[slot_idx];
	assign make_new = !live_now && owed_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue && (live_now || owed_any);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end else begin
			v_s4 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= slot_idx;
			new_s1 <= make_new;
			for (int k = 0; k < 3; k++) rd_s1[k] <= mem_ax[k][slot_idx];
			life_s1 <= mem_life[slot_idx];
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ain[k].pos = new_s1 ? org_q[k] : rd_s1[k].pos;
			ain[k].vel = new_s1 ? vel0_q[k] : rd_s1[k].vel;
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_axis
		pet_axis u_axis (
			.clk (clk),
			.en  (adv),
			.dt  (dt_q),
			.acc (accel_q[16*g +: 16]),
			.din (ain[g]),
			.dout(aout[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2 <= idx_s1;
			life_s2 <= new_s1 ? pet_pkg::LIFE_ONE : life_s1;
			ldec_s2 <= life_decay_q * dt_q;
			idx_s3 <= idx_s2;
			life_s3 <= life_s2 - ldec_s2[pet_pkg::LIFE_W-1:0];
			alive_s3 <= (pet_pkg::LIFE_W+pet_pkg::DT_W)'(life_s2) > ldec_s2;
		end
	end

	// s4: writeback into the memories and the holding record
	always_ff @(posedge clk) begin
		adv_s4_q <= adv;
		if (adv) begin
			idx_s4_q <= idx_s3;
			alive_s4_q <= alive_s3;
		end
		if (adv && v_s3) begin
			for (int k = 0; k < 3; k++) mem_ax[k][idx_s3] <= aout[k];
			mem_life[idx_s3] <= life_s3;
		end
	end

	// holding record: one alive particle waits for the next to know last
	logic take_hold, send_hold, send_empty;
	assign take_hold = adv && v_s3 && alive_s3;
	assign send_hold = hold_v_q && out_free &&
		(take_hold || (state_q == ST_DRAIN && !pipe_busy));
	assign send_empty = (state_q == ST_EMPTY) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take_hold) hold_v_q <= 1'b1;
			else if (send_hold) hold_v_q <= 1'b0;
			if (send_hold || send_empty) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hold) begin
			for (int k = 0; k < 3; k++) h_pos_q[k] <= aout[k].pos;
			h_life_q <= life_s3;
		end
		if (send_hold) begin
			r_valid_q <= 1'b1;
			r_last_q <= !take_hold;
			for (int k = 0; k < 3; k++) r_pos_q[k] <= h_pos_q[k];
			r_life_q <= h_life_q;
			r_drop_q <= drop_q;
		end else if (send_empty) begin
			r_valid_q <= 1'b0;
			r_last_q <= 1'b1;
			for (int k = 0; k < 3; k++) r_pos_q[k] <= '0;
			r_life_q <= '0;
			r_drop_q <= drop_q;
		end
	end

	assign out_valid = out_v_q;
	assign valid_res = r_valid_q;
	assign last = r_last_q;
	assign pos_x = r_pos_q[0];
	assign pos_y = r_pos_q[1];
	assign pos_z = r_pos_q[2];
	assign life_left = r_life_q;
	assign dropped_count = r_drop_q;
endmodule
